// File: hdl/sdvp_pkg.sv
// sdvp_pkg: shared types and constants for the slow-down velocity profiler
// used by sdvp_iter and slow_down_velocity_profiler; no dependencies

package sdvp_pkg;

   // shift-subtract unit sizes
   localparam int SRC_W  = 64;   // operand shifted in from the top
   localparam int RES_W  = 33;   // root or quotient
   localparam int REM_W  = 36;   // partial remainder
   localparam int DEN_W  = 17;   // divisor, twice the expand range
   localparam int STEP_W = 6;    // step counter

   // step counts for the three jobs of the unit
   localparam logic [STEP_W-1:0] SQRT64_STEPS = 6'd32;
   localparam logic [STEP_W-1:0] SQRT32_STEPS = 6'd16;
   localparam logic [STEP_W-1:0] DIV_STEPS    = 6'd33;

   // command from the sequencer to the shared unit
   typedef struct packed {
      logic                start;
      logic                is_div;
      logic [STEP_W-1:0]   steps;
   } sdvp_iter_cmd_type;

endpackage

// File: hdl/sdvp_iter.sv
// sdvp_iter: shared shift-subtract unit, floored square root or unsigned division
// one result bit per cycle; depends on sdvp_pkg

module sdvp_iter import sdvp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  sdvp_iter_cmd_type    cmd,
   input  logic [SRC_W-1:0]     src,
   input  logic [DEN_W-1:0]     den,
   output logic                 done,
   output logic [RES_W-1:0]     result
);

   logic                busy_ff;
   logic                done_ff;
   logic                is_div_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [SRC_W-1:0]    src_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [RES_W-1:0]    res_ff;

   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;
   logic                take;
   logic [REM_W-1:0]    rem_in;
   logic [RES_W-1:0]    res_in;
   logic [SRC_W-1:0]    src_in;

   // one digit: bring down bits, compare against trial, subtract
   always_comb begin
      if (is_div_ff) begin
         rem_sh = {rem_ff[REM_W-2:0], src_ff[SRC_W-1]};
         trial  = REM_W'(den_ff);
         src_in = {src_ff[SRC_W-2:0], 1'b0};
      end else begin
         rem_sh = {rem_ff[REM_W-3:0], src_ff[SRC_W-1 -: 2]};
         trial  = {1'b0, res_ff, 2'b01};
         src_in = {src_ff[SRC_W-3:0], 2'b00};
      end
      take   = (rem_sh >= trial);
      rem_in = take ? (rem_sh - trial) : rem_sh;
      res_in = {res_ff[RES_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // pulse after the last step
         done_ff <= !cmd.start && busy_ff && (cnt_ff == STEP_W'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_div_ff <= cmd.is_div;
         src_ff    <= src;
         den_ff    <= den;
         rem_ff    <= '0;
         res_ff    <= '0;
      end else if (busy_ff) begin
         src_ff <= src_in;
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("iter: start while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("iter: done while busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == STEP_W'(1)) |=> done_ff)
      else $error("iter: last step gave no done");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && is_div_ff) |-> (rem_ff < REM_W'(den_ff)))
      else $error("iter: division remainder not below divisor");
`endif

endmodule

// File: hdl/slow_down_velocity_profiler.sv
// slow_down_velocity_profiler: top level, stream ports, register file and sequencer
// depends on sdvp_pkg and sdvp_iter

// Limits the velocity of trajectory points behind a slow-down start point. A word
// with req_tuser set opens a run: initial_velocity becomes the limit and a target
// min + (max-min)*max(deviation - width/2, 0)/range is worked out (saturated to
// 16 bits). Each later word of the run lowers the limit as if braking at max_decel
// over the floored distance from the previous point, never below the target, and
// gets min(limit, point_velocity); the word with req_tlast passes unchanged and
// closes the run. Words outside a run pass unchanged. One word is in work at a
// time and req_tready is low meanwhile; a finished result waits in the output
// register while the next word is taken. A run start costs a 33-step division,
// other run points a 32-step distance root plus a 16-step velocity root, fewer
// when the limit falls straight to the target. All roots and the division share
// one shift-subtract unit, all products one registered 32x32 multiplier.
// Registers: 0x00 max_decel, 0x04 min_slow_velocity, 0x08 max_slow_velocity,
// 0x0c expand_range, 0x10 body_width; write them only while idle.

module slow_down_velocity_profiler import sdvp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // input words
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,  // pos_x, pos_y, point_velocity,
                                     // initial_velocity, obstacle_offset
   input  logic          req_tuser,  // run_start
   input  logic          req_tlast,  // run_last
   // result words
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,  // limited_velocity
   output logic          rsp_tlast,  // last_out
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_MAX_DECEL = 3'd0;
   localparam logic [2:0] REG_MIN_SLOW  = 3'd1;
   localparam logic [2:0] REG_MAX_SLOW  = 3'd2;
   localparam logic [2:0] REG_RANGE     = 3'd3;
   localparam logic [2:0] REG_WIDTH     = 3'd4;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIFF  = 4'd1;
   localparam logic [3:0] ST_SQX   = 4'd2;
   localparam logic [3:0] ST_SQY   = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_DIST  = 4'd5;
   localparam logic [3:0] ST_BRAKE = 4'd6;
   localparam logic [3:0] ST_V2    = 4'd7;
   localparam logic [3:0] ST_SUB   = 4'd8;
   localparam logic [3:0] ST_ROOT  = 4'd9;
   localparam logic [3:0] ST_LIMIT = 4'd10;
   localparam logic [3:0] ST_TPREP = 4'd11;
   localparam logic [3:0] ST_TMUL  = 4'd12;
   localparam logic [3:0] ST_TDIV  = 4'd13;
   localparam logic [3:0] ST_TWAIT = 4'd14;
   localparam logic [3:0] ST_APPLY = 4'd15;

   // configuration registers
   logic [14:0]  max_decel_ff;
   logic [15:0]  min_slow_ff;
   logic [15:0]  max_slow_ff;
   logic [15:0]  expand_range_ff;
   logic [12:0]  body_width_ff;

   // run state
   logic         run_active_ff;
   logic [31:0]  prev_x_ff;
   logic [31:0]  prev_y_ff;
   logic [15:0]  limit_ff;
   logic [15:0]  target_ff;

   // word in work
   logic [3:0]   state_ff;
   logic [3:0]   state_in;
   logic [31:0]  x_ff;
   logic [31:0]  y_ff;
   logic [15:0]  vel_ff;
   logic         last_ff;
   logic [15:0]  dev_ff;

   // datapath registers
   logic [32:0]  ax_ff;
   logic [32:0]  ay_ff;
   logic [63:0]  prod_ff;
   logic [63:0]  acc_ff;
   logic [15:0]  root_ff;
   logic [15:0]  mag_ff;
   logic         neg_ff;
   logic [16:0]  exc_ff;

   // output register
   logic         rsp_valid_ff;
   logic [15:0]  rsp_data_ff;
   logic         rsp_last_ff;

   logic         req_accept;
   logic         cfg_write;
   logic         rsp_free;

   logic [31:0]  mul_a;
   logic [31:0]  mul_b;

   sdvp_iter_cmd_type  iter_cmd;
   logic [SRC_W-1:0]   iter_src;
   logic [DEN_W-1:0]   iter_den;
   logic               iter_done;
   logic [RES_W-1:0]   iter_result;

   logic [32:0]  dxp;
   logic [32:0]  dxn;
   logic [32:0]  dyp;
   logic [32:0]  dyn;
   logic         huge;
   logic [63:0]  v2_left;
   logic [15:0]  range_eff;
   logic [16:0]  diff_p;
   logic [16:0]  diff_n;
   logic [17:0]  excess;
   logic [32:0]  div_num;
   logic [33:0]  tgt_up;
   logic [15:0]  tgt_sat;
   logic [15:0]  rsp_value;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // register read
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_MAX_DECEL: csr_prdata = {17'b0, max_decel_ff};
         REG_MIN_SLOW:  csr_prdata = {16'b0, min_slow_ff};
         REG_MAX_SLOW:  csr_prdata = {16'b0, max_slow_ff};
         REG_RANGE:     csr_prdata = {16'b0, expand_range_ff};
         REG_WIDTH:     csr_prdata = {19'b0, body_width_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_decel_ff     <= 15'd1000;
         min_slow_ff      <= 16'd1000;
         max_slow_ff      <= 16'd5000;
         expand_range_ff  <= 16'd1000;
         body_width_ff    <= 13'd2000;
      end else if (cfg_write) begin
         unique case (csr_paddr[4:2])
            REG_MAX_DECEL: max_decel_ff     <= csr_pwdata[14:0];
            REG_MIN_SLOW:  min_slow_ff      <= csr_pwdata[15:0];
            REG_MAX_SLOW:  max_slow_ff      <= csr_pwdata[15:0];
            REG_RANGE:     expand_range_ff  <= csr_pwdata[15:0];
            REG_WIDTH:     body_width_ff    <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // coordinate differences, both signs at once so abs is a mux
   assign dxp  = {x_ff[31], x_ff} - {prev_x_ff[31], prev_x_ff};
   assign dxn  = {prev_x_ff[31], prev_x_ff} - {x_ff[31], x_ff};
   assign dyp  = {y_ff[31], y_ff} - {prev_y_ff[31], prev_y_ff};
   assign dyn  = {prev_y_ff[31], prev_y_ff} - {y_ff[31], y_ff};

   // with braking on, a step of 2^31 mm or more brakes any 16-bit velocity to zero
   assign huge = ax_ff[32] || ax_ff[31] || ay_ff[32] || ay_ff[31];

   // v^2 minus braking term, only used when it is positive (below 2^32)
   assign v2_left = prod_ff - acc_ff;

   // target pieces: max-min as magnitude and sign, clearance excess doubled
   assign range_eff = (expand_range_ff == 16'd0) ? 16'd1 : expand_range_ff;
   assign diff_p    = {1'b0, max_slow_ff} - {1'b0, min_slow_ff};
   assign diff_n    = {1'b0, min_slow_ff} - {1'b0, max_slow_ff};
   assign excess    = {1'b0, dev_ff, 1'b0} - {5'b0, body_width_ff};

   // a falling target rounds the quotient up so min - quotient stays floored
   assign div_num = prod_ff[32:0] + (neg_ff ? (33'(iter_den) - 33'd1) : 33'd0);

   // target = min +/- quotient, saturated into 16 bits
   always_comb begin
      tgt_up = 34'(min_slow_ff) + 34'(iter_result);
      if (neg_ff) begin
         if (iter_result > 33'(min_slow_ff)) tgt_sat = 16'd0;
         else tgt_sat = min_slow_ff - iter_result[15:0];
      end else begin
         if (tgt_up > 34'(16'hFFFF)) tgt_sat = 16'hFFFF;
         else tgt_sat = tgt_up[15:0];
      end
   end

   // value handed out for the word in work
   assign rsp_value = (run_active_ff && !last_ff && (limit_ff < vel_ff)) ? limit_ff : vel_ff;

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_SQX:   begin mul_a = ax_ff[31:0];           mul_b = ax_ff[31:0]; end
         ST_SQY:   begin mul_a = ay_ff[31:0];           mul_b = ay_ff[31:0]; end
         ST_BRAKE: begin mul_a = {17'b0, max_decel_ff}; mul_b = iter_result[31:0]; end
         ST_V2:    begin mul_a = {16'b0, limit_ff};     mul_b = {16'b0, limit_ff}; end
         ST_TMUL:  begin mul_a = {16'b0, mag_ff};       mul_b = {15'b0, exc_ff}; end
         default:  begin mul_a = '0;                    mul_b = '0; end
      endcase
   end

   // shared root/divide unit commands
   always_comb begin
      iter_cmd        = '0;
      iter_cmd.is_div = (state_ff == ST_TDIV);
      iter_src        = '0;
      iter_den        = {range_eff, 1'b0};
      case (state_ff)
         ST_SUM: begin
            // distance = isqrt(dx^2 + dy^2)
            iter_cmd.start = 1'b1;
            iter_cmd.steps = SQRT64_STEPS;
            iter_src       = acc_ff + prod_ff;
         end
         ST_SUB: begin
            // new limit = isqrt(v^2 - brake), value left-aligned for 16 steps
            iter_cmd.start = (acc_ff < prod_ff);
            iter_cmd.steps = SQRT32_STEPS;
            iter_src       = {v2_left[31:0], 32'b0};
         end
         ST_TDIV: begin
            // |max-min| * excess / (2*range)
            iter_cmd.start = 1'b1;
            iter_cmd.steps = DIV_STEPS;
            iter_src       = {div_num, 31'b0};
         end
         default: ;
      endcase
   end

   sdvp_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (iter_cmd),
      .src    (iter_src),
      .den    (iter_den),
      .done   (iter_done),
      .result (iter_result)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) state_in = ST_TPREP;
               else if (run_active_ff) state_in = ST_DIFF;
               else state_in = ST_APPLY;
            end
         end
         ST_DIFF:  state_in = ST_SQX;
         ST_SQX: begin
            if (max_decel_ff == 15'd0 || huge) state_in = ST_LIMIT;
            else state_in = ST_SQY;
         end
         ST_SQY:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIST;
         ST_DIST:  if (iter_done) state_in = ST_BRAKE;
         ST_BRAKE: state_in = ST_V2;
         ST_V2:    state_in = ST_SUB;
         ST_SUB:   state_in = (acc_ff < prod_ff) ? ST_ROOT : ST_LIMIT;
         ST_ROOT:  if (iter_done) state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_APPLY;
         ST_TPREP: state_in = ST_TMUL;
         ST_TMUL:  state_in = ST_TDIV;
         ST_TDIV:  state_in = ST_TWAIT;
         ST_TWAIT: if (iter_done) state_in = ST_APPLY;
         ST_APPLY: if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_active_ff <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         limit_ff      <= '0;
         target_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // a new result may replace one taken in the same cycle
         if (state_ff == ST_APPLY && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_tuser) begin
                  run_active_ff <= 1'b1;
                  limit_ff      <= req_tdata[95:80];
               end
            end
            ST_TWAIT: if (iter_done) target_ff <= tgt_sat;
            ST_LIMIT: limit_ff <= (root_ff > target_ff) ? root_ff : target_ff;
            ST_APPLY: begin
               if (rsp_free) begin
                  if (run_active_ff) begin
                     prev_x_ff <= x_ff;
                     prev_y_ff <= y_ff;
                     if (last_ff) run_active_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= {32'b0, mul_a} * {32'b0, mul_b};
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_ff    <= req_tdata[31:0];
               y_ff    <= req_tdata[63:32];
               vel_ff  <= req_tdata[79:64];
               dev_ff  <= req_tdata[111:96];
               last_ff <= req_tlast;
            end
         end
         ST_DIFF: begin
            ax_ff <= dxp[32] ? dxn : dxp;
            ay_ff <= dyp[32] ? dyn : dyp;
         end
         ST_SQX: begin
            // no deceleration keeps the limit, a huge step drops it to the target
            if (max_decel_ff == 15'd0) root_ff <= limit_ff;
            else root_ff <= '0;
         end
         ST_SQY:  acc_ff <= prod_ff;
         ST_V2:   acc_ff <= {prod_ff[62:0], 1'b0};
         ST_SUB:  root_ff <= '0;
         ST_ROOT: if (iter_done) root_ff <= iter_result[15:0];
         ST_TPREP: begin
            neg_ff <= diff_p[16];
            mag_ff <= diff_p[16] ? diff_n[15:0] : diff_p[15:0];
            exc_ff <= excess[17] ? 17'd0 : excess[16:0];
         end
         ST_APPLY: begin
            if (rsp_free) begin
               rsp_data_ff <= rsp_value;
               rsp_last_ff <= last_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_root_not_up: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIMIT) |-> (root_ff <= limit_ff))
      else $error("braking raised the limit");

   a_iter_waited: assert property (@(posedge clock) disable iff (reset)
      iter_done |-> (state_ff == ST_DIST || state_ff == ST_ROOT || state_ff == ST_TWAIT))
      else $error("root/divide result arrived outside a wait state");

   a_apply_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_APPLY))
      else $error("result written over a waiting word");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("word taken but sequencer idle");
`endif

endmodule

// File: verif/slow_down_velocity_profiler_tb.sv
// slow_down_velocity_profiler_tb: self-checking bench for the slow-down velocity profiler
// drives trajectory words and register writes, predicts every result word and compares
// depends on sdvp_pkg and slow_down_velocity_profiler

module slow_down_velocity_profiler_tb;
   import sdvp_pkg::*;

   // register indexes, byte address is four times the index
   localparam int REG_MAX_DECEL  = 0;
   localparam int REG_MIN_SLOW   = 1;
   localparam int REG_MAX_SLOW   = 2;
   localparam int REG_RANGE      = 3;
   localparam int REG_WIDTH      = 4;

   localparam int STALL_LIMIT    = 4000;  // cycles with no word moving on either side
   localparam int SETTLE_CYCLES  = 100;
   localparam int REPORT_LIMIT   = 50;

   // one expected result word
   typedef struct packed {
      logic [15:0] vel;
      logic        last;
   } velocity_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;   // pos_x, pos_y, point_velocity,
                                    // initial_velocity, obstacle_offset
   logic          req_tuser = 1'b0; // run_start
   logic          req_tlast = 1'b0; // run_last
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;        // limited_velocity
   logic          rsp_tlast;        // last_out
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [4:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   slow_down_velocity_profiler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers, reset values
   int cfg_decel    = 1000;
   int cfg_min_slow = 1000;
   int cfg_max_slow = 5000;
   int cfg_range    = 1000;
   int cfg_width    = 2000;

   // predictor copy of the run state
   logic signed [31:0] trk_prev_x = '0;
   logic signed [31:0] trk_prev_y = '0;
   logic [15:0]        trk_limit  = '0;
   logic [15:0]        trk_target = '0;
   logic               trk_active = 1'b0;

   velocity_word_type expected_velocity_q[$];
   velocity_word_type checked_word;
   int             mismatch_count = 0;
   int             words_sent = 0;
   int             idle_pct = 38;
   int             stall_cycles = 0;
   int             walk_x = 0;
   int             walk_y = 0;

   // floored square root, one result bit at a time from the top
   function automatic bit [63:0] floor_sqrt(bit [63:0] val);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= val) root = trial;
      end
      return root;
   endfunction

   // target velocity from the lateral deviation, division floored toward minus infinity
   function automatic logic [15:0] slow_target(logic [15:0] dev);
      longint span, excess, den, num, quot, tgt;
      span = longint'(cfg_max_slow) - longint'(cfg_min_slow);
      excess = 2 * longint'(dev) - longint'(cfg_width);
      if (excess < 0) excess = 0;
      den = 2 * ((cfg_range == 0) ? 64'sd1 : longint'(cfg_range));
      num = span * excess;
      quot = (num >= 0) ? num / den : -((-num + den - 1) / den);
      tgt = longint'(cfg_min_slow) + quot;
      if (tgt < 0) tgt = 0;
      if (tgt > 65535) tgt = 65535;
      return tgt[15:0];
   endfunction

   // limit after braking over the floored distance from the previous point
   function automatic logic [15:0] braked_limit(logic signed [31:0] x, logic signed [31:0] y);
      longint    dx, dy;
      bit [63:0] ax, ay, path_len, brake, vsq, root;
      dx = longint'(x) - longint'(trk_prev_x);
      dy = longint'(y) - longint'(trk_prev_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      vsq = 64'(trk_limit) * 64'(trk_limit);
      if (cfg_decel == 0) begin
         root = 64'(trk_limit);
      end else if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
         // braking term exceeds any 16-bit speed
         root = '0;
      end else begin
         path_len = floor_sqrt(ax * ax + ay * ay);
         brake = 64'(2) * 64'(cfg_decel) * path_len;
         root = (brake >= vsq) ? 64'd0 : floor_sqrt(vsq - brake);
      end
      return (root > 64'(trk_target)) ? root[15:0] : trk_target;
   endfunction

   // next state and result for one accepted point
   function automatic velocity_word_type apply_slow_down(logic signed [31:0] x,
         logic signed [31:0] y, logic [15:0] v, logic start, logic last,
         logic [15:0] init, logic [15:0] dev);
      velocity_word_type w;
      w.vel = v;
      w.last = last;
      if (start) begin
         trk_limit = init;
         trk_target = slow_target(dev);
         trk_active = 1'b1;
      end else if (trk_active) begin
         trk_limit = braked_limit(x, y);
      end
      if (trk_active) begin
         if (!last && trk_limit < v) w.vel = trk_limit;
         trk_prev_x = x;
         trk_prev_y = y;
         if (last) trk_active = 1'b0;
      end
      return w;
   endfunction

   function automatic void flag_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
   endfunction

   // random speed or deviation, mostly in the range where braking matters
   function automatic int pick_magnitude();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 9000);
   endfunction

   // send one trajectory word, predicting its result at the accepting edge
   task automatic send_point(int x, int y, int v, bit start, bit last, int init, int dev);
      velocity_word_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {dev[15:0], init[15:0], v[15:0], y, x};
      req_tuser  <= start;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_slow_down(x, y, v[15:0], start, last, init[15:0], dev[15:0]);
      expected_velocity_q = {expected_velocity_q, predicted};
      words_sent++;
   endtask

   // stop sending and wait until every expected word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_velocity_q.size() != 0) @(posedge clock);
   endtask

   // setup cycle then access cycle, register takes the value on the access edge
   task automatic write_reg(int idx, int val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(idx * 4);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MAX_DECEL: cfg_decel    = val & 32'h7fff;
         REG_MIN_SLOW:  cfg_min_slow = val & 32'hffff;
         REG_MAX_SLOW:  cfg_max_slow = val & 32'hffff;
         REG_RANGE:     cfg_range    = val & 32'hffff;
         REG_WIDTH:     cfg_width    = val & 32'h1fff;
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_profile(int decel, int min_v, int max_v, int span, int width);
      write_reg(REG_MAX_DECEL, decel);
      write_reg(REG_MIN_SLOW, min_v);
      write_reg(REG_MAX_SLOW, max_v);
      write_reg(REG_RANGE, span);
      write_reg(REG_WIDTH, width);
   endtask

   // extreme coordinates and speeds under the reset register values
   task automatic test_field_extremes();
      send_point(32'h8000_0000, 32'h7fff_ffff, 65535, 1, 0, 65535, 65535);
      send_point(32'h8000_0064, 32'h7fff_ffff, 65535, 0, 0, 0, 0);
      send_point(0, 0, 0, 0, 0, 65535, 65535);
      send_point(32'h7fff_ffff, 32'h8000_0000, 65535, 0, 1, 0, 0);
   endtask

   // words outside a run pass through and leave the state alone
   task automatic test_outside_run();
      send_point($urandom, $urandom, 123, 0, 0, 65535, 65535);
      send_point($urandom, $urandom, 40000, 0, 1, 0, 0);
   endtask

   // start and last on one word: state latched, word unchanged, run closed
   task automatic test_start_and_last();
      send_point(1000, 2000, 9000, 1, 1, 100, 3000);
      send_point(1100, 2000, 9000, 0, 0, 100, 3000);
   endtask

   // inverted min/max, zero expand range, saturation of the target
   task automatic test_target_corners();
      drain_results();
      load_profile(1000, 5000, 1000, 0, 0);
      send_point(0, 0, 30000, 1, 0, 20000, 40000);
      send_point(3000, 4000, 30000, 0, 0, 0, 0);
      send_point(6000, 8000, 30000, 0, 1, 0, 0);
      drain_results();
      load_profile(1000, 0, 65535, 1, 8000);
      send_point(0, 0, 65535, 1, 0, 60000, 65535);
      send_point(-500000, 700000, 65535, 0, 0, 0, 0);
      send_point(-500000, 700001, 65535, 0, 1, 0, 0);
   endtask

   // coordinate jumps of 2^31 mm or more, with braking off and with strong braking
   task automatic test_huge_steps();
      drain_results();
      load_profile(0, 1000, 5000, 1000, 2000);
      send_point(32'h8000_0000, 0, 9000, 1, 0, 3000, 1500);
      send_point(32'h7fff_ffff, 0, 9000, 0, 0, 0, 0);
      send_point(32'h7fff_ffff, 10, 9000, 0, 1, 0, 0);
      drain_results();
      write_reg(REG_MAX_DECEL, 20000);
      send_point(0, 32'h7fff_0000, 9000, 1, 0, 8000, 1800);
      send_point(0, 32'h8000_0000, 9000, 0, 0, 0, 0);
      send_point(0, 32'h8000_0001, 9000, 0, 1, 0, 0);
   endtask

   // registers rewritten inside a run: target stays, deceleration is read live
   task automatic test_config_mid_run();
      drain_results();
      load_profile(1000, 1000, 5000, 1000, 2000);
      send_point(0, 0, 12000, 1, 0, 8000, 1500);
      send_point(1000, 0, 12000, 0, 0, 0, 0);
      drain_results();
      write_reg(REG_MAX_DECEL, 5000);
      write_reg(REG_MIN_SLOW, 3000);
      send_point(2000, 500, 12000, 0, 0, 0, 0);
      send_point(2600, 900, 12000, 0, 1, 0, 0);
   endtask

   // random runs under several register settings, extremes among them
   task automatic test_random_runs();
      int phase_end, mid_count, step_max, step;
      for (int phase = 0; phase < 8; phase++) begin
         // the sender holds off until every result is back before each setting
         drain_results();
         case (phase)
            0: load_profile(1000, 1000, 5000, 1000, 2000);
            1: load_profile(20000, 0, 65535, 1, 8000);
            2: load_profile(0, 65535, 0, 65535, 0);
            3: load_profile(1, 500, 3000, 65535, 4000);
            default: load_profile($urandom_range(0, 20000), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(1, 65535),
                                  $urandom_range(0, 8000));
         endcase
         // first setting runs with no idling on either side
         idle_pct = (phase == 0) ? 0 : 38;
         phase_end = words_sent + 155;
         while (words_sent < phase_end) begin
            // stray word, outside a run or inside an unclosed one
            if ($urandom_range(0, 9) == 0)
               send_point($urandom, $urandom, $urandom_range(0, 65535), 0,
                          $urandom_range(0, 1), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            case ($urandom_range(0, 2))
               0: step_max = 200;
               1: step_max = 3000;
               default: step_max = 40000;
            endcase
            if ($urandom_range(0, 7) == 0) begin
               walk_x = $urandom;
               walk_y = $urandom;
            end
            send_point(walk_x, walk_y, pick_magnitude(), 1, 0, pick_magnitude(),
                       pick_magnitude());
            mid_count = $urandom_range(0, 8);
            for (int k = 0; k <= mid_count; k++) begin
               if ($urandom_range(0, 29) == 0) begin
                  walk_x = $urandom;
                  walk_y = $urandom;
               end else begin
                  step = $urandom_range(0, step_max);
                  walk_x += $urandom_range(0, 1) ? step : -step;
                  step = $urandom_range(0, step_max);
                  walk_y += $urandom_range(0, 1) ? step : -step;
               end
               // final word closes the run, except in a broken run
               if (k < mid_count || $urandom_range(0, 9) != 0)
                  send_point(walk_x, walk_y, pick_magnitude(), 0, k == mid_count,
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
         end
      end
      idle_pct = 38;
   endtask

   // result side stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_velocity_q.size() == 0) begin
            flag_mismatch("unexpected word, pending", 0, 1);
         end else begin
            checked_word = expected_velocity_q.pop_front();
            if (rsp_tdata !== checked_word.vel)
               flag_mismatch("limited_velocity", checked_word.vel, rsp_tdata);
            if (rsp_tlast !== checked_word.last)
               flag_mismatch("last_out", checked_word.last, rsp_tlast);
         end
      end
   end

   // watchdog on words moving in either direction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout with %0d words pending", $time, expected_velocity_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_outside_run();
      test_start_and_last();
      test_target_corners();
      test_huge_steps();
      test_config_mid_run();
      test_random_runs();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_velocity_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
